// ----- sv/ltd_pkg.sv -----
// Shared types and constants for the LZ77 triplet decoder.
// No dependencies; used by lz77_triplet_decoder.
`default_nettype none

package ltd_pkg;

    // Field widths of the input triplet and the result word
    localparam int OFF_W      = 16;
    localparam int LEN_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int WORD_BYTES = 8;
    localparam int IDX_W      = 3;
    localparam int CNT_W      = 4;
    localparam int IN_W       = OFF_W + LEN_W + BYTE_W;
    localparam int OUT_W      = WORD_BYTES * BYTE_W;

    // Byte producer sequencing
    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_LIT,
        S_FLUSH
    } t_state;

endpackage

`default_nettype wire

// ----- sv/lz77_triplet_decoder.sv -----
// LZ77 triplet decoder: history memory, byte sequencer and output packing.
// Depends on ltd_pkg.
`default_nettype none

// One triplet (distance, length, literal) is taken per input beat while the
// block is idle. It produces one byte per clock while the output is not
// stalled: the copied bytes, then the literal if nonzero, each written back
// into a HISTORY_SIZE-byte circular history and packed eight to an output
// beat, first byte in the low bits, count in tuser and tlast on the triplet's
// final beat. A triplet that copies from the history first issues a
// read-ahead, then produces its bytes and the literal if nonzero, then
// flushes the last word before the next triplet is accepted; a zero-distance
// copy needs no read-ahead. The history memory is read once and written once
// per cycle, with a registered read. Backpressure on the output beat pauses
// the byte sequencer. The history needs no clearing after reset: the copy
// distance is clamped to the number of bytes written so far. A triplet with
// zero length and a zero literal produces no output beat.
module lz77_triplet_decoder #(
    parameter int HISTORY_SIZE = 4096
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // tdata: match_offset[15:0], match_length[23:16], literal[31:24]
    input  wire                      s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire [ltd_pkg::IN_W-1:0]  s_axis_tdata,
    // tdata: out_bytes[63:0]
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    output logic [ltd_pkg::OUT_W-1:0] m_axis_tdata,
    // tuser: byte_count[3:0]
    output logic [ltd_pkg::CNT_W-1:0] m_axis_tuser,
    output logic                     m_axis_tlast
);

    localparam int AW = $clog2(HISTORY_SIZE);
    localparam int FW = $clog2(HISTORY_SIZE + 1);
    localparam int CW = (FW > ltd_pkg::OFF_W) ? FW : ltd_pkg::OFF_W;

    // Input fields
    logic [ltd_pkg::OFF_W-1:0]  in_off;
    logic [ltd_pkg::LEN_W-1:0]  in_len;
    logic [ltd_pkg::BYTE_W-1:0] in_lit;

    assign in_off = s_axis_tdata[ltd_pkg::OFF_W-1:0];
    assign in_len = s_axis_tdata[ltd_pkg::OFF_W +: ltd_pkg::LEN_W];
    assign in_lit = s_axis_tdata[ltd_pkg::OFF_W + ltd_pkg::LEN_W +: ltd_pkg::BYTE_W];

    // State registers
    ltd_pkg::t_state r_state, n_state;
    logic [AW-1:0]              r_wp;
    logic [FW-1:0]              r_fill;
    logic [AW-1:0]              r_rd_addr;
    logic [ltd_pkg::LEN_W-1:0]  r_left;
    logic                       r_zero;
    logic [ltd_pkg::BYTE_W-1:0] r_lit;
    logic                       r_bv;
    logic [ltd_pkg::BYTE_W-1:0] r_rd_data;
    logic                       r_fwd;
    logic [ltd_pkg::BYTE_W-1:0] r_fwd_byte;
    logic [ltd_pkg::OUT_W-1:0]  r_acc, n_acc;
    logic [ltd_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_ov;
    logic [ltd_pkg::OUT_W-1:0]  r_out;
    logic [ltd_pkg::CNT_W-1:0]  r_out_cnt;
    logic                       r_out_last;

    logic [ltd_pkg::BYTE_W-1:0] r_hist [HISTORY_SIZE];

    // Control
    logic                       accept;
    logic                       avail;
    logic                       can_produce;
    logic                       produce;
    logic                       issue;
    logic                       last_copy;
    logic                       xfer;
    logic [ltd_pkg::BYTE_W-1:0] prod_byte;
    logic [ltd_pkg::BYTE_W-1:0] mem_byte;
    logic [ltd_pkg::IDX_W-1:0]  ins_idx;
    logic [AW-1:0]              wp_next;
    logic [AW-1:0]              rd_next;

    // Copy start: clamp distance to fill, step back from write pointer
    logic [CW-1:0] off_ext;
    logic [CW-1:0] fill_ext;
    logic [CW-1:0] dist_c;
    logic [FW-1:0] dist_f;
    logic [FW-1:0] wp_f;
    logic [FW-1:0] size_f;
    logic [FW-1:0] start_f;

    always_comb begin
        off_ext  = CW'(in_off);
        fill_ext = CW'(r_fill);
        dist_c   = (off_ext < fill_ext) ? off_ext : fill_ext;
        dist_f   = FW'(dist_c);
        wp_f     = FW'(r_wp);
        size_f   = FW'(HISTORY_SIZE);
        start_f  = (wp_f >= dist_f) ? (wp_f - dist_f) : (wp_f + size_f - dist_f);
    end

    assign wp_next = (r_wp == AW'(HISTORY_SIZE - 1)) ? '0 : r_wp + 1'b1;
    assign rd_next = (r_rd_addr == AW'(HISTORY_SIZE - 1)) ? '0 : r_rd_addr + 1'b1;
    assign mem_byte = r_fwd ? r_fwd_byte : r_rd_data;

    // Sequencer outputs
    always_comb begin
        accept    = 1'b0;
        avail     = 1'b0;
        prod_byte = '0;
        case (r_state)
            ltd_pkg::S_IDLE: begin
                accept = s_axis_tvalid;
            end
            ltd_pkg::S_COPY: begin
                avail     = r_zero ? (r_left != '0) : r_bv;
                prod_byte = r_zero ? '0 : mem_byte;
            end
            ltd_pkg::S_LIT: begin
                avail     = 1'b1;
                prod_byte = r_lit;
            end
            ltd_pkg::S_FLUSH: begin
                avail = 1'b0;
            end
            default: begin
                avail = 1'b0;
            end
        endcase

        xfer = (!r_ov || m_axis_tready) &&
               ((r_cnt == ltd_pkg::CNT_W'(ltd_pkg::WORD_BYTES)) ||
                (r_state == ltd_pkg::S_FLUSH));
        can_produce = (r_cnt != ltd_pkg::CNT_W'(ltd_pkg::WORD_BYTES)) || xfer;
        produce     = avail && can_produce;
        issue       = (r_state == ltd_pkg::S_COPY) && !r_zero && (r_left != '0) &&
                      (!r_bv || produce);
        last_copy   = (r_state == ltd_pkg::S_COPY) && produce &&
                      (r_zero ? (r_left == ltd_pkg::LEN_W'(1)) : (r_left == '0));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ltd_pkg::S_IDLE: begin
                if (accept) begin
                    if (in_len != '0) begin
                        n_state = ltd_pkg::S_COPY;
                    end else if (in_lit != '0) begin
                        n_state = ltd_pkg::S_LIT;
                    end
                end
            end
            ltd_pkg::S_COPY: begin
                if (last_copy) begin
                    n_state = (r_lit != '0) ? ltd_pkg::S_LIT : ltd_pkg::S_FLUSH;
                end
            end
            ltd_pkg::S_LIT: begin
                if (produce) begin
                    n_state = ltd_pkg::S_FLUSH;
                end
            end
            ltd_pkg::S_FLUSH: begin
                if (xfer) begin
                    n_state = ltd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ltd_pkg::S_IDLE;
            end
        endcase
    end

    // Pack the produced byte into the assembly word
    always_comb begin
        n_acc   = xfer ? '0 : r_acc;
        n_cnt   = xfer ? '0 : r_cnt;
        ins_idx = xfer ? '0 : r_cnt[ltd_pkg::IDX_W-1:0];
        if (produce) begin
            n_acc[ltd_pkg::BYTE_W*ins_idx +: ltd_pkg::BYTE_W] = prod_byte;
            n_cnt = n_cnt + 1'b1;
        end
    end

    // History memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_hist[r_wp] <= prod_byte;
        end
        if (issue) begin
            r_rd_data <= r_hist[r_rd_addr];
        end
    end

    // Forward the byte written in the same cycle as a read of that entry
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_fwd      <= produce && (r_rd_addr == r_wp);
            r_fwd_byte <= prod_byte;
        end
    end

    // Triplet payload, read address and remaining count
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left    <= in_len;
            r_zero    <= (dist_f == '0);
            r_lit     <= in_lit;
            r_rd_addr <= start_f[AW-1:0];
        end else begin
            if (issue) begin
                r_rd_addr <= rd_next;
            end
            if (issue || (r_zero && produce && r_state == ltd_pkg::S_COPY)) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_out      <= r_acc;
            r_out_cnt  <= r_cnt;
            r_out_last <= (r_state == ltd_pkg::S_FLUSH);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltd_pkg::S_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
            r_bv    <= 1'b0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            if (produce) begin
                r_wp <= wp_next;
                if (r_fill != FW'(HISTORY_SIZE)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (issue) begin
                r_bv <= 1'b1;
            end else if (produce && r_state == ltd_pkg::S_COPY) begin
                r_bv <= 1'b0;
            end
            if (xfer) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign s_axis_tready = (r_state == ltd_pkg::S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_out_cnt;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // Assembly word never overfills
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ltd_pkg::CNT_W'(ltd_pkg::WORD_BYTES))
        else $error("assembly count above word size");

    // A new triplet starts with an empty assembly word
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_cnt == '0))
        else $error("triplet accepted with bytes pending");

    // Read data in flight only during a history copy
    a_bv_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bv |-> (r_state == ltd_pkg::S_COPY && !r_zero))
        else $error("read data pending outside copy");

    // Final word of a triplet returns to idle with tlast set
    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && r_state == ltd_pkg::S_FLUSH) |=>
            (r_state == ltd_pkg::S_IDLE && m_axis_tvalid && m_axis_tlast))
        else $error("final word not marked last");

    // Fill count never shrinks
    a_fill_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fill >= $past(r_fill)))
        else $error("fill count decreased");
`endif

endmodule

`default_nettype wire
